### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/pest_pkg.sv
// Shared types, constants and command decode for the escape sequence tokenizer.
package pest_pkg;

  localparam int TOKEN_BYTES_DEF = 32;

  localparam logic [7:0] ESC_CODE = 8'h1b;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic decode;
    logic rd;
    logic put;
    logic put_last;
    logic single;
    logic post;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dec_drain;
    logic dec_single;
    logic dec_post;
    logic drain_last;
    logic out_free;
  } status_t;

  // True when a class, group and command combination is followed by byte data.
  function automatic logic carries_data(input logic [7:0] c, input logic [7:0] g,
                                        input logic [7:0] k);
    logic r;
    r = 1'b0;
    case (c)
      "&": r = ((g inside {"a", "b", "n"}) && k == "W") || (g == "p" && k == "X");
      "(": r = (g inside {"f", "s"}) && k == "W";
      ")": r = g == "s" && k == "W";
      "*": begin
        if (g == "b") r = k == "V" || k == "W";
        else r = (g inside {"c", "g", "i", "l", "m", "o", "v"}) && k == "W";
      end
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/pest_if.sv
// Valid/ready channel interfaces for the tokenizer's input and output items.
interface pest_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_job;

  modport source (output valid, output in_byte, output end_of_job, input ready);
  modport sink (input valid, input in_byte, input end_of_job, output ready);
endinterface

interface pest_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       chunk_end;
  logic       last;

  modport source (output valid, output out_byte, output chunk_end, output last, input ready);
  modport sink (input valid, input out_byte, input chunk_end, input last, output ready);
endinterface

### hw/rtl/pest_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pest_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

### hw/rtl/pest_dp.sv
// Tokenizer datapath: parse registers, byte decode, token buffer and output register.
module pest_dp #(
  parameter int TOKEN_BYTES = pest_pkg::TOKEN_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pest_pkg::cmd_t    cmd,
  output pest_pkg::status_t st,
  input  logic [7:0]        in_byte,
  input  logic              end_of_job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              chunk_end,
  output logic              last
);
  import pest_pkg::*;

  localparam int LEN_W  = $clog2(TOKEN_BYTES + 1);
  localparam int ADDR_W = $clog2(TOKEN_BYTES);
  localparam logic [LEN_W-1:0] TB_LEN = LEN_W'(TOKEN_BYTES);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  localparam logic [2:0] P_IDLE        = 3'd0;
  localparam logic [2:0] P_ESC         = 3'd1;
  localparam logic [2:0] P_ESC_Q       = 3'd2;
  localparam logic [2:0] P_AFTER_CLASS = 3'd3;
  localparam logic [2:0] P_PARAM       = 3'd4;
  localparam logic [2:0] P_COMBINED    = 3'd5;

  localparam logic [7:0]  DC1_CODE    = 8'h11;
  localparam logic [22:0] PARAM_LIMIT = 23'd655350;

  typedef struct packed {
    logic [2:0]  pstate;
    logic [7:0]  cls;
    logic [7:0]  grp;
    logic        neg;
    logic [22:0] accum;
    logic        digit;
  } parse_t;

  parse_t           pr, pr_next;
  logic [LEN_W-1:0] len, len_next, len_inc, dlen, dlen_cand, idx;
  logic [22:0]      payload, payload_next;
  logic [7:0]       in_r;
  logic             eoj_r;
  logic             full, is_esc, is_param, is_upper, is_lower;
  logic             wr_first, drain, single, post;

  // Parameter byte effects.
  logic        np_neg, np_digit;
  logic [22:0] np_accum, accum_x10;
  logic [3:0]  digit_val;

  // Command end effects.
  logic [7:0]  g_eff, k_cmd;
  logic [22:0] ec_count;
  logic        ec_data, ec_fits, ec_combined;
  logic [LEN_W-1:0] room;

  logic [7:0]  rd_data;

  assign full     = (len == TB_LEN);
  assign len_inc  = len + LEN_ONE;
  assign is_esc   = (in_r == ESC_CODE);
  assign is_param = in_r inside {[8'h20:8'h3f]};
  assign is_upper = in_r inside {[8'h40:8'h5e]};
  assign is_lower = in_r inside {[8'h60:8'h7e]};

  assign digit_val = 4'(in_r - 8'h30);
  assign accum_x10 = {pr.accum[19:0], 3'b000} + {pr.accum[21:0], 1'b0};

  always_comb begin
    np_neg   = pr.neg;
    np_digit = pr.digit;
    np_accum = pr.accum;
    if (in_r inside {[8'h30:8'h39]}) begin
      np_digit = 1'b1;
      if (pr.accum <= PARAM_LIMIT) np_accum = accum_x10 + 23'(digit_val);
    end else if (!pr.digit && in_r == "-") begin
      np_neg = 1'b1;
    end else if (!pr.digit && in_r == "+") begin
      np_neg = 1'b0;
    end
  end

  assign g_eff       = (pr.pstate == P_AFTER_CLASS) ? 8'h00 : pr.grp;
  assign k_cmd       = is_lower ? in_r - 8'd32 : in_r;
  assign ec_count    = (pr.neg || !pr.digit) ? 23'd0 : pr.accum;
  assign ec_data     = carries_data(pr.cls, g_eff, k_cmd);
  assign ec_combined = is_lower && !ec_data;
  assign room        = TB_LEN - len_inc;
  assign ec_fits     = ec_data && ec_count != 23'd0 && ec_count <= 23'(room);

  // Decode of the held item; applied on the decode command.
  always_comb begin
    pr_next      = pr;
    len_next     = len;
    payload_next = payload;
    wr_first     = 1'b0;
    drain        = 1'b0;
    single       = 1'b0;
    post         = 1'b0;
    if (eoj_r) begin
      drain    = 1'b1;
      len_next = '0;
      pr_next  = '0;
    end else if (payload != 23'd0) begin
      payload_next = payload - 23'd1;
      if (len != '0) begin
        if (full) begin
          drain    = 1'b1;
          len_next = '0;
          pr_next  = '0;
          single   = 1'b1;
        end else begin
          wr_first = 1'b1;
          len_next = len_inc;
          if (payload == 23'd1 || len_inc == TB_LEN) begin
            drain    = 1'b1;
            len_next = '0;
            pr_next  = '0;
          end
        end
      end else begin
        single = 1'b1;
      end
    end else begin
      case (pr.pstate)
        P_ESC, P_AFTER_CLASS, P_PARAM, P_COMBINED: begin
          if (full) begin
            // The byte does not fit: flush, then treat it as an idle byte.
            drain    = 1'b1;
            len_next = '0;
            pr_next  = '0;
            if (is_esc) begin
              post           = 1'b1;
              pr_next.pstate = P_ESC;
            end else begin
              single = 1'b1;
            end
          end else begin
            wr_first = 1'b1;
            len_next = len_inc;
            if (is_esc) begin
              pr_next        = '0;
              pr_next.pstate = P_ESC;
            end else if (pr.pstate == P_ESC) begin
              if (in_r == "?") begin
                pr_next.pstate = P_ESC_Q;
              end else if (in_r inside {[8'h21:8'h2f]}) begin
                pr_next        = '0;
                pr_next.cls    = in_r;
                pr_next.pstate = P_AFTER_CLASS;
              end else begin
                drain    = 1'b1;
                len_next = '0;
                pr_next  = '0;
              end
            end else if (pr.pstate == P_AFTER_CLASS && is_lower) begin
              pr_next.grp    = in_r;
              pr_next.neg    = 1'b0;
              pr_next.accum  = '0;
              pr_next.digit  = 1'b0;
              pr_next.pstate = P_PARAM;
            end else if (is_param) begin
              pr_next.grp   = g_eff;
              pr_next.neg   = np_neg;
              pr_next.accum = np_accum;
              pr_next.digit = np_digit;
              if (pr.pstate == P_AFTER_CLASS) pr_next.pstate = P_PARAM;
            end else if (is_upper || is_lower) begin
              pr_next.grp   = g_eff;
              pr_next.neg   = 1'b0;
              pr_next.accum = '0;
              pr_next.digit = 1'b0;
              if (ec_fits) begin
                payload_next   = ec_count;
                pr_next.pstate = P_IDLE;
              end else begin
                drain    = 1'b1;
                len_next = '0;
                if (ec_data && ec_count != 23'd0) payload_next = ec_count;
                pr_next.pstate = ec_combined ? P_COMBINED : P_IDLE;
              end
            end else begin
              drain    = 1'b1;
              len_next = '0;
              pr_next  = '0;
            end
          end
        end
        P_ESC_Q: begin
          if (in_r == DC1_CODE) begin
            // ESC ? DC1 is dropped entirely.
            len_next = '0;
            pr_next  = '0;
          end else begin
            drain    = 1'b1;
            len_next = '0;
            pr_next  = '0;
            if (is_esc) begin
              post           = 1'b1;
              pr_next.pstate = P_ESC;
            end else begin
              single = 1'b1;
            end
          end
        end
        default: begin
          if (is_esc) begin
            if (full) begin
              drain          = 1'b1;
              len_next       = '0;
              pr_next        = '0;
              pr_next.pstate = P_ESC;
            end else begin
              wr_first       = 1'b1;
              len_next       = len_inc;
              pr_next.pstate = P_ESC;
            end
          end else begin
            single = 1'b1;
          end
        end
      endcase
    end
  end

  assign dlen_cand = wr_first ? len_inc : len;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr      <= '0;
      len     <= '0;
      payload <= '0;
    end else if (cmd.decode) begin
      pr      <= pr_next;
      len     <= len_next;
      payload <= payload_next;
    end else if (cmd.post) begin
      len <= LEN_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r  <= in_byte;
      eoj_r <= end_of_job;
    end
    if (cmd.decode) begin
      dlen <= dlen_cand;
      idx  <= '0;
    end else if (cmd.put) begin
      idx <= idx + LEN_ONE;
    end
  end

  pest_ram #(
    .WIDTH (8),
    .DEPTH (TOKEN_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    ((cmd.decode && wr_first) || cmd.post),
    .waddr (cmd.post ? ADDR_W'(0) : len[ADDR_W-1:0]),
    .wdata (cmd.post ? ESC_CODE : in_r),
    .re    (cmd.rd),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // Output register parts the drain from the downstream handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put || cmd.single) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.single) begin
      out_byte  <= in_r;
      chunk_end <= 1'b1;
      last      <= 1'b1;
    end else if (cmd.put) begin
      out_byte  <= rd_data;
      chunk_end <= st.drain_last;
      last      <= st.drain_last && cmd.put_last;
    end
  end

  assign st.dec_drain  = drain && (dlen_cand != '0);
  assign st.dec_single = single;
  assign st.dec_post   = post;
  assign st.drain_last = ((idx + LEN_ONE) == dlen);
  assign st.out_free   = !out_valid || out_ready;
endmodule

### hw/rtl/pest_ctrl.sv
// Tokenizer controller: sequences accept, decode, token drain, single-byte output and escape write-back.
module pest_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pest_pkg::status_t st,
  output pest_pkg::cmd_t    cmd
);
  import pest_pkg::*;

  localparam logic [2:0] S_WAIT   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_SINGLE = 3'd4;
  localparam logic [2:0] S_POST   = 3'd5;

  logic [2:0] state, state_next;
  logic       pend_single, pend_single_next;
  logic       pend_post, pend_post_next;

  always_comb begin
    cmd              = '0;
    state_next       = state;
    pend_single_next = pend_single;
    pend_post_next   = pend_post;
    in_ready         = 1'b0;
    case (state)
      S_WAIT: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode       = 1'b1;
        pend_single_next = st.dec_single;
        pend_post_next   = st.dec_post;
        if (st.dec_drain) begin
          state_next = S_READ;
        end else if (st.dec_single) begin
          // A lone byte goes straight to the output register when it is free.
          if (st.out_free) begin
            cmd.single = 1'b1;
            state_next = S_WAIT;
          end else begin
            state_next = S_SINGLE;
          end
        end else if (st.dec_post) begin
          state_next = S_POST;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_PUT;
      end
      S_PUT: begin
        if (st.out_free) begin
          cmd.put      = 1'b1;
          cmd.put_last = !pend_single;
          if (!st.drain_last) state_next = S_READ;
          else if (pend_single) state_next = S_SINGLE;
          else if (pend_post) state_next = S_POST;
          else state_next = S_WAIT;
        end
      end
      S_SINGLE: begin
        if (st.out_free) begin
          cmd.single = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_POST: begin
        cmd.post   = 1'b1;
        state_next = S_WAIT;
      end
      default: state_next = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_WAIT;
      pend_single <= 1'b0;
      pend_post   <= 1'b0;
    end else begin
      state       <= state_next;
      pend_single <= pend_single_next;
      pend_post   <= pend_post_next;
    end
  end
endmodule

### hw/rtl/printer_escape_sequence_tokenizer.sv
// Top level of the printer escape sequence tokenizer.
// Takes one stream byte per input item and emits bytes grouped into chunks:
// plain bytes pass through as one-byte chunks, escape sequences are gathered
// in a TOKEN_BYTES-deep buffer RAM and emitted as one chunk when they end, and
// data-carrying commands take their byte payload into the same chunk when it
// fits. An item that only passes a byte through or only adds a byte to the
// buffer is accepted and then decoded. A token flush reads each buffered
// byte from the buffer RAM and then loads it into the output register; a
// byte that follows the flush is then loaded on its own, and a restarted
// escape is written back to the buffer. Output stalls stretch these steps;
// the output register lets a result wait while the next item is taken.
module printer_escape_sequence_tokenizer #(
  parameter int TOKEN_BYTES = pest_pkg::TOKEN_BYTES_DEF
) (
  input logic      clk,
  input logic      rst,
  pest_in_if.sink  stream,
  pest_out_if.source chunks
);
  import pest_pkg::*;

  cmd_t    cmd;
  status_t st;

  pest_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_ready (stream.ready),
    .st       (st),
    .cmd      (cmd)
  );

  pest_dp #(
    .TOKEN_BYTES (TOKEN_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_byte    (stream.in_byte),
    .end_of_job (stream.end_of_job),
    .out_valid  (chunks.valid),
    .out_ready  (chunks.ready),
    .out_byte   (chunks.out_byte),
    .chunk_end  (chunks.chunk_end),
    .last       (chunks.last)
  );
endmodule

### hw/rtl/pest_checker.sv
// Port-level checks for the tokenizer, bound to its top level.
`include "assert_macros.svh"

module pest_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic chunk_end,
  input logic last
);
  // A stalled result must stay offered.
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  // The last result of an item always closes a chunk.
  `ASSERT_CLK(a_last_closes, clk, rst, out_valid && last |-> chunk_end, "last result without chunk end")
  // An accepted item is decoded before another one is taken.
  `ASSERT_CLK(a_one_item, clk, rst, in_valid && in_ready |=> !in_ready, "item taken during decode")
  // Reset empties the output register.
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result offered after reset")
endmodule

bind printer_escape_sequence_tokenizer pest_checker u_pest_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (stream.valid),
  .in_ready  (stream.ready),
  .out_valid (chunks.valid),
  .out_ready (chunks.ready),
  .chunk_end (chunks.chunk_end),
  .last      (chunks.last)
);

### verif/tb_top.sv
// Self-checking testbench for the printer escape sequence tokenizer.
module tb_top;
  import pest_pkg::*;

  localparam int TOK_DEPTH = TOKEN_BYTES_DEF;
  localparam logic [7:0] DC1_CODE = 8'h11;
  localparam int PARAM_CAP = 655350;
  localparam int RANDOM_ITEMS = 430;
  localparam int PAUSE_AT = 300;
  localparam int STALL_AFTER = 150;
  localparam int LONG_STALL = 400;
  localparam int TAIL_CYCLES = 200;
  // About 450 items, each up to 33 results at the sparsest receiver rate,
  // plus sender gaps and the long receiver stall, taken several times over.
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    PS_IDLE, PS_ESC, PS_ESC_Q, PS_AFTER_CLASS, PS_PARAM, PS_COMBINED
  } parse_state_t;

  typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_job;
    logic       wait_idle;
  } job_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       chunk_end;
    logic       last;
  } chunk_res_t;

  logic clk;
  logic rst;

  pest_in_if stream_if();
  pest_out_if chunk_if();

  printer_escape_sequence_tokenizer i_dut (
    .clk(clk),
    .rst(rst),
    .stream(stream_if),
    .chunks(chunk_if)
  );

  job_item_t  pend_q[$];
  chunk_res_t due_q[$];

  // Mirror of the tokenizer state.
  parse_state_t ps;
  logic [7:0]   tok_buf [TOK_DEPTH];
  int           tok_len;
  logic [7:0]   cls_b;
  logic [7:0]   grp_b;
  logic         par_neg;
  logic         par_seen;
  logic [22:0]  par_val;
  logic [22:0]  pay_left;
  int           n_new;

  int         err_cnt = 0;
  int         cycle_cnt = 0;
  int         n_accepted = 0;
  bit         in_taken = 1'b0;
  bit         offering = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  bit         stall_done = 1'b0;
  int         rx_phase = 0;
  rx_mode_t   rx_mode = RX_FREE;
  chunk_res_t got_res;
  chunk_res_t want_res;

  string data_cls = "&&&&(()*********";
  string data_grp = "abnpfssbbcgilmov";
  string data_cmd = "WWWXWWWVWWWWWWWW";

  function automatic bit is_lower(input logic [7:0] v);
    return v >= 8'h60 && v <= 8'h7e;
  endfunction

  function automatic bit is_param(input logic [7:0] v);
    return v >= 8'h20 && v <= 8'h3f;
  endfunction

  function automatic bit is_upper_cmd(input logic [7:0] v);
    return v >= 8'h40 && v <= 8'h5e;
  endfunction

  function automatic bit takes_payload(input logic [7:0] c, input logic [7:0] g,
                                       input logic [7:0] k);
    bit r;
    r = 1'b0;
    case (c)
      "&": r = ((g == "a" || g == "b" || g == "n") && k == "W") || (g == "p" && k == "X");
      "(": r = (g == "f" || g == "s") && k == "W";
      ")": r = g == "s" && k == "W";
      "*": begin
        if (g == "b") r = k == "V" || k == "W";
        else r = (g == "c" || g == "g" || g == "i" || g == "l" || g == "m" ||
                  g == "o" || g == "v") && k == "W";
      end
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic void queue_result(input logic [7:0] b, input logic e);
    chunk_res_t r;
    r.data = b;
    r.chunk_end = e;
    r.last = 1'b0;
    due_q.push_back(r);
    n_new++;
  endfunction

  function automatic void clear_param();
    par_neg = 1'b0;
    par_val = '0;
    par_seen = 1'b0;
  endfunction

  function automatic void emit_buffer();
    for (int i = 0; i < tok_len; i++) queue_result(tok_buf[i], i + 1 == tok_len);
  endfunction

  function automatic void flush_token();
    emit_buffer();
    tok_len = 0;
    ps = PS_IDLE;
    cls_b = '0;
    grp_b = '0;
    clear_param();
  endfunction

  function automatic bit append_token(input logic [7:0] v);
    if (tok_len >= TOK_DEPTH) begin
      flush_token();
      return 1'b0;
    end
    tok_buf[tok_len] = v;
    tok_len++;
    return 1'b1;
  endfunction

  function automatic void resync();
    ps = PS_ESC;
    cls_b = '0;
    grp_b = '0;
    clear_param();
  endfunction

  function automatic void note_param(input logic [7:0] v);
    if (v >= "0" && v <= "9") begin
      par_seen = 1'b1;
      if (int'(par_val) <= PARAM_CAP) par_val = par_val * 23'd10 + 23'(v - 8'h30);
    end else if (!par_seen && v == "-") begin
      par_neg = 1'b1;
    end else if (!par_seen && v == "+") begin
      par_neg = 1'b0;
    end
  endfunction

  function automatic void end_command(input logic [7:0] v);
    logic [7:0]  k;
    logic [22:0] count;
    bit          has_data;
    bit          combined;
    k = is_lower(v) ? v - 8'd32 : v;
    count = (par_neg || !par_seen) ? '0 : par_val;
    has_data = takes_payload(cls_b, grp_b, k);
    combined = is_lower(v) && !has_data;
    if (has_data && count != 0 && int'(count) <= TOK_DEPTH - tok_len) begin
      // The payload joins the buffered token.
      pay_left = count;
      ps = PS_IDLE;
    end else begin
      emit_buffer();
      tok_len = 0;
      if (has_data && count != 0) pay_left = count;
      ps = combined ? PS_COMBINED : PS_IDLE;
    end
    clear_param();
  endfunction

  function automatic void idle_byte(input logic [7:0] v);
    if (v == ESC_CODE) begin
      void'(append_token(v));
      ps = PS_ESC;
    end else begin
      queue_result(v, 1'b1);
    end
  endfunction

  function automatic void tokenize_byte(input logic [7:0] v);
    if (pay_left != 0) begin
      if (tok_len != 0) begin
        if (tok_len >= TOK_DEPTH) flush_token();
        if (tok_len != 0) begin
          tok_buf[tok_len] = v;
          tok_len++;
        end else begin
          queue_result(v, 1'b1);
        end
        pay_left--;
        if (pay_left == 0 || tok_len >= TOK_DEPTH) flush_token();
      end else begin
        queue_result(v, 1'b1);
        pay_left--;
      end
    end else begin
      case (ps)
        PS_ESC: begin
          if (!append_token(v)) idle_byte(v);
          else if (v == ESC_CODE) resync();
          else if (v == "?") ps = PS_ESC_Q;
          else if (v >= 8'h21 && v <= 8'h2f) begin
            cls_b = v;
            grp_b = '0;
            clear_param();
            ps = PS_AFTER_CLASS;
          end else flush_token();
        end
        PS_ESC_Q: begin
          if (v == DC1_CODE) begin
            // The whole sequence is dropped.
            tok_len = 0;
            ps = PS_IDLE;
            cls_b = '0;
            grp_b = '0;
            clear_param();
          end else begin
            flush_token();
            idle_byte(v);
          end
        end
        PS_AFTER_CLASS: begin
          if (!append_token(v)) idle_byte(v);
          else if (is_lower(v)) begin
            grp_b = v;
            clear_param();
            ps = PS_PARAM;
          end else if (is_param(v)) begin
            grp_b = '0;
            note_param(v);
            ps = PS_PARAM;
          end else if (is_upper_cmd(v)) begin
            grp_b = '0;
            end_command(v);
          end else if (v == ESC_CODE) resync();
          else flush_token();
        end
        PS_PARAM, PS_COMBINED: begin
          if (!append_token(v)) idle_byte(v);
          else if (is_param(v)) note_param(v);
          else if (is_upper_cmd(v) || is_lower(v)) end_command(v);
          else if (v == ESC_CODE) resync();
          else flush_token();
        end
        default: idle_byte(v);
      endcase
    end
  endfunction

  function automatic void tokenize_item(input logic [7:0] b, input logic eoj);
    chunk_res_t r;
    n_new = 0;
    if (eoj) flush_token();
    else tokenize_byte(b);
    if (n_new > 0) begin
      r = due_q.pop_back();
      r.last = 1'b1;
      due_q.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Stimulus helpers.
  task automatic push_item(input logic [7:0] b, input logic eoj);
    job_item_t it;
    it.in_byte = b;
    it.end_of_job = eoj;
    // One item waits until every expected result has arrived.
    it.wait_idle = pend_q.size() == PAUSE_AT;
    pend_q.push_back(it);
  endtask

  task automatic add_byte(input logic [7:0] b);
    push_item(b, 1'b0);
  endtask

  task automatic add_eoj();
    push_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic add_number(input int n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_value();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      // No digits at all.
    end else if (r == 1) begin
      add_byte("-");
      add_number($urandom_range(0, 40));
    end else if (r == 2) begin
      add_number($urandom_range(0, 9));
      add_byte(".");
      add_number($urandom_range(0, 9));
    end else begin
      add_number($urandom_range(0, 40));
    end
  endtask

  task automatic add_data_command();
    int         idx;
    int         pick;
    int         count;
    logic [7:0] cmd;
    idx = $urandom_range(0, 15);
    pick = $urandom_range(0, 19);
    count = 0;
    add_byte(ESC_CODE);
    add_byte(data_cls[idx]);
    add_byte(data_grp[idx]);
    // Sometimes a lowercase command without data comes first in the same sequence.
    if ($urandom_range(0, 2) == 0) begin
      add_number($urandom_range(0, 40));
      add_byte(8'($urandom_range(8'h61, 8'h75)));
    end
    if (pick < 13) begin
      count = $urandom_range(1, 12);
      add_number(count);
    end else if (pick < 16) begin
      count = $urandom_range(20, 40);
      add_number(count);
    end else if (pick == 16) begin
      add_byte("-");
      add_number($urandom_range(1, 99));
    end else if (pick == 17) begin
      add_byte("0");
    end else if (pick == 18) begin
      add_byte("+");
    end else begin
      count = $urandom_range(1, 8);
      add_byte("+");
      add_number(count);
    end
    cmd = data_cmd[idx];
    if ($urandom_range(0, 1) == 1) cmd = cmd + 8'd32;
    add_byte(cmd);
    repeat (count) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_combined();
    int    steps;
    string classes;
    classes = "&(*";
    steps = $urandom_range(0, 3);
    add_byte(ESC_CODE);
    add_byte(classes[$urandom_range(0, 2)]);
    if ($urandom_range(0, 3) != 0) add_byte(8'($urandom_range(8'h61, 8'h75)));
    repeat (steps) begin
      add_value();
      add_byte(8'($urandom_range(8'h61, 8'h75)));
    end
    add_value();
    add_byte(8'($urandom_range(8'h41, 8'h55)));
  endtask

  task automatic add_big_value();
    add_byte(ESC_CODE);
    if ($urandom_range(0, 1) == 1) begin
      add_byte("&");
      add_byte("l");
      // Values around the accumulation cap.
      if ($urandom_range(0, 1) == 1) add_number(65535);
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(8'h30, 8'h39)));
      add_byte("H");
    end else begin
      add_byte("*");
      add_byte("b");
      add_byte("-");
      repeat ($urandom_range(6, 9)) add_byte(8'($urandom_range(8'h30, 8'h39)));
      add_byte("W");
    end
  endtask

  task automatic add_overflow();
    add_byte(ESC_CODE);
    add_byte("&");
    add_byte("l");
    repeat ($urandom_range(28, 45)) add_byte(8'($urandom_range(8'h20, 8'h3f)));
    add_byte("H");
  endtask

  task automatic add_broken();
    add_byte(ESC_CODE);
    add_byte("&");
    add_byte("l");
    add_value();
    case ($urandom_range(0, 3))
      0: add_byte(8'($urandom_range(0, 8'h1a)));
      1: begin
        // Stray ESC restarts the sequence.
        add_byte(ESC_CODE);
        add_byte("&");
        add_byte("l");
        add_value();
        add_byte("H");
      end
      2: add_eoj();
      default: add_byte(8'($urandom_range(8'h7f, 8'hff)));
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    stream_if.valid = 1'b0;
    stream_if.in_byte = '0;
    stream_if.end_of_job = 1'b0;
    chunk_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    int sel;
    int base;
    ps = PS_IDLE;
    tok_len = 0;
    cls_b = '0;
    grp_b = '0;
    clear_param();
    pay_left = '0;

    add_byte("A");
    add_byte(8'hff);
    add_byte(8'h00);
    add_byte(ESC_CODE);
    add_byte("?");
    add_byte(DC1_CODE);
    add_byte(ESC_CODE);
    add_byte("?");
    add_byte("Z");
    add_byte(ESC_CODE);
    add_byte("*");
    add_byte("b");
    add_byte("2");
    add_byte("W");
    add_byte(8'haa);
    add_byte(8'h55);
    add_byte(ESC_CODE);
    add_byte("&");
    add_eoj();
    add_eoj();
    add_byte(ESC_CODE);
    add_byte(ESC_CODE);
    add_byte("E");

    base = pend_q.size();
    while (pend_q.size() < base + RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 26) add_data_command();
      else if (sel < 42) add_combined();
      else if (sel < 50) begin
        add_byte(ESC_CODE);
        add_byte("?");
        if ($urandom_range(0, 3) != 0) add_byte(DC1_CODE);
        else add_byte(8'($urandom_range(0, 255)));
      end else if (sel < 58) begin
        add_byte(ESC_CODE);
        add_byte(8'($urandom_range(0, 255)));
      end else if (sel < 63) add_big_value();
      else if (sel < 68) add_overflow();
      else if (sel < 78) add_broken();
      else if (sel < 96) repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      else add_eoj();
    end
    add_eoj();

    @(negedge rst);
    while (pend_q.size() != 0 || due_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Sender: bursts of items with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      stream_if.valid <= 1'b0;
    end else begin
      if (in_taken) begin
        void'(pend_q.pop_front());
        in_taken = 1'b0;
        offering = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!offering) begin
        // Gaps are skipped during the long receiver stall to fill the block.
        if (gap_left > 0 && stall_left == 0) begin
          gap_left--;
        end else if (pend_q.size() != 0 && !(pend_q[0].wait_idle && due_q.size() != 0)) begin
          offering = 1'b1;
          stream_if.in_byte <= pend_q[0].in_byte;
          stream_if.end_of_job <= pend_q[0].end_of_job;
        end
      end
      stream_if.valid <= offering;
    end
  end

  // Receiver: phases of free flow and stalls, plus one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      chunk_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      chunk_if.ready <= 1'b0;
    end else if (!stall_done && n_accepted >= STALL_AFTER) begin
      stall_done = 1'b1;
      stall_left = LONG_STALL;
      chunk_if.ready <= 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_phase = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0, 1: rx_mode = RX_FREE;
          2: rx_mode = RX_HALF;
          default: rx_mode = RX_SPARSE;
        endcase
      end
      rx_phase--;
      case (rx_mode)
        RX_FREE: chunk_if.ready <= 1'b1;
        RX_HALF: chunk_if.ready <= 1'($urandom_range(0, 1));
        default: chunk_if.ready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // Monitor: predicts on each accepted input item and checks each result.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (!rst) begin
      if (stream_if.valid && stream_if.ready) begin
        tokenize_item(stream_if.in_byte, stream_if.end_of_job);
        in_taken = 1'b1;
        n_accepted++;
      end
      if (chunk_if.valid && chunk_if.ready) begin
        got_res.data = chunk_if.out_byte;
        got_res.chunk_end = chunk_if.chunk_end;
        got_res.last = chunk_if.last;
        if (due_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, got byte %0h end %b last %b",
                   $time, got_res.data, got_res.chunk_end, got_res.last);
        end else begin
          want_res = due_q.pop_front();
          check_field("out_byte", want_res.data, got_res.data);
          check_field("chunk_end", want_res.chunk_end, got_res.chunk_end);
          check_field("last", want_res.last, got_res.last);
        end
      end
    end
  end

endmodule
